// ----- hw/rtl/bcd_to_binary_converter_top_defines.svh -----
// Assertion macros for the converter top level.
`ifndef BCD_TO_BINARY_CONVERTER_TOP_DEFINES_SVH
`define BCD_TO_BINARY_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define BCDB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define BCDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bcdb_pkg.sv -----
// Constants and types of the BCD to binary converter.
package bcdb_pkg;

  localparam int DIGITS_DEFAULT = 8;
  localparam int IN_W           = 32;
  localparam int NIB_W          = 4;
  localparam int VALUE_W        = 27;
  localparam int LEN_W          = 5;
  localparam int OUT_W          = 32;

  localparam logic [NIB_W-1:0] CORR_THRESH = 4'd8;
  localparam logic [NIB_W-1:0] CORR_SUB    = 4'd3;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/bcdb_cell.sv -----
// One digit cell: shift right by one bit, then subtract three from 8 and above.
module bcdb_cell (
  input  logic                           clk,
  input  bcdb_pkg::cell_ctrl_t           ctrl,
  input  logic [bcdb_pkg::NIB_W-1:0]     load_nib,
  input  logic                           bit_in,
  output logic                           bit_out,
  output logic                           zero
);

  logic [bcdb_pkg::NIB_W-1:0] nib;
  logic [bcdb_pkg::NIB_W-1:0] shifted;
  logic [bcdb_pkg::NIB_W-1:0] nib_next;

  always_comb begin
    shifted = {bit_in, nib[bcdb_pkg::NIB_W-1:1]};
    if (shifted >= bcdb_pkg::CORR_THRESH) begin
      nib_next = shifted - bcdb_pkg::CORR_SUB;
    end else begin
      nib_next = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      nib <= load_nib;
    end else if (ctrl.shift) begin
      nib <= nib_next;
    end
  end

  assign bit_out = nib[0];
  assign zero    = (nib == '0);

endmodule

// ----- hw/rtl/bcd_to_binary_converter_top.sv -----
// Top level of the BCD to binary converter: digit cell row, step control, output register.
//
//   channel  | dir | tdata fields (low bit up)                 | accepted when
//   s_axis   | in  | bcd_digits[31:0]                          | tvalid && tready
//   m_axis   | out | binary_value[26:0], bit_length[31:27]     | tvalid && tready
//
// An item is loaded into the single digit row, then shifted once per significant
// result bit (bit_length, at most 27 for decimal input), then moved to the output
// register once that register is free. The next item is taken once the row has
// handed its result over, even while the output register still waits for
// m_axis_tready.
// rst is synchronous and clears the busy and output valid flags.
`include "bcd_to_binary_converter_top_defines.svh"

module bcd_to_binary_converter_top #(
  parameter int DIGITS = bcdb_pkg::DIGITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bcdb_pkg::IN_W-1:0]     s_axis_tdata,   // bcd_digits[31:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bcdb_pkg::OUT_W-1:0]    m_axis_tdata    // binary_value[26:0], bit_length[31:27]
);

  localparam int IN_DIGITS = bcdb_pkg::IN_W / bcdb_pkg::NIB_W;

  logic                          busy;
  logic [bcdb_pkg::LEN_W-1:0]    step_cnt;
  logic [bcdb_pkg::VALUE_W-1:0]  value;
  logic [bcdb_pkg::VALUE_W-1:0]  out_value;
  logic [bcdb_pkg::LEN_W-1:0]    out_len;

  bcdb_pkg::cell_ctrl_t          ctrl;
  logic [bcdb_pkg::NIB_W-1:0]    load_nib [DIGITS];
  logic [DIGITS:0]               chain;
  logic [DIGITS-1:0]             cell_zero;
  logic                          all_zero;
  logic                          out_free;
  logic                          finish;

  assign s_axis_tready = !busy;
  assign all_zero      = (cell_zero == '0) ? 1'b0 : (&cell_zero);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign finish        = busy && all_zero && out_free;

  always_comb begin
    ctrl.load  = s_axis_tvalid && s_axis_tready;
    ctrl.shift = busy && !all_zero;
  end

  // Top cell takes zeros in from above.
  assign chain[DIGITS] = 1'b0;

  genvar k;
  generate
    for (k = 0; k < DIGITS; k++) begin : g_cell
      if (k < IN_DIGITS) begin : g_in
        assign load_nib[k] = s_axis_tdata[bcdb_pkg::NIB_W*k +: bcdb_pkg::NIB_W];
      end else begin : g_pad
        assign load_nib[k] = '0;
      end

      bcdb_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .load_nib (load_nib[k]),
        .bit_in   (chain[k+1]),
        .bit_out  (chain[k]),
        .zero     (cell_zero[k])
      );
    end
  endgenerate

  // Collect result bits, least significant first; count steps, saturating.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value    <= '0;
      step_cnt <= '0;
    end else if (ctrl.shift) begin
      if (32'(step_cnt) < bcdb_pkg::VALUE_W) begin
        value[step_cnt] <= chain[0];
      end
      if (step_cnt != '1) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.load) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_value <= value;
      out_len   <= step_cnt;
    end
  end

  assign m_axis_tdata = {out_len, out_value};

  `BCDB_ASSERT_NEXT(a_load_busy, ctrl.load, busy && step_cnt == '0 && value == '0, "load did not start a conversion")
  `BCDB_ASSERT_NEXT(a_step_count, ctrl.shift && step_cnt != '1, step_cnt == $past(step_cnt) + 1'b1, "step count did not advance")
  `BCDB_ASSERT_NEXT(a_finish_out, finish, m_axis_tvalid && !busy && m_axis_tdata == {$past(step_cnt), $past(value)}, "result not moved to output")
  `BCDB_ASSERT_NOW(a_no_load_busy, busy, !ctrl.load, "item taken while converting")

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the BCD to binary converter: stream stimulus, value predictor and result checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int IN_W    = bcdb_pkg::IN_W;
  localparam int NIB_W   = bcdb_pkg::NIB_W;
  localparam int VALUE_W = bcdb_pkg::VALUE_W;
  localparam int LEN_W   = bcdb_pkg::LEN_W;
  localparam int OUT_W   = bcdb_pkg::OUT_W;
  localparam logic [NIB_W-1:0] CORR_THRESH = bcdb_pkg::CORR_THRESH;
  localparam logic [NIB_W-1:0] CORR_SUB    = bcdb_pkg::CORR_SUB;

  localparam int NUM_DIGITS   = bcdb_pkg::DIGITS_DEFAULT;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_RANDOM  = 0;
  localparam int IDLE_NONE    = 1;
  localparam int IDLE_SPARSE  = 2;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } conv_result_t;

  class conv_checker;
    conv_result_t pending_values[$];
    int           items_in;
    int           items_high_digit;
    int           results_checked;
    int           fail_count;
    int           reported;

    // Shift the digit row right, collect the dropped bit, pull each digit of 8+ down by 3.
    function automatic conv_result_t convert_bcd(input logic [IN_W-1:0] digits);
      logic [IN_W-1:0] shreg;
      logic [63:0]     acc;
      int              steps;
      conv_result_t    res;
      shreg = digits;
      acc   = '0;
      steps = 0;
      while (shreg != '0 && steps < 64) begin
        acc[steps] = shreg[0];
        shreg      = shreg >> 1;
        steps++;
        for (int k = 0; k < NUM_DIGITS; k++) begin
          if (shreg[NIB_W*k +: NIB_W] >= CORR_THRESH)
            shreg[NIB_W*k +: NIB_W] = shreg[NIB_W*k +: NIB_W] - CORR_SUB;
        end
      end
      res.value = acc[VALUE_W-1:0];
      res.len   = (steps > 31) ? 5'd31 : steps[LEN_W-1:0];
      return res;
    endfunction

    function automatic void note_digits(input logic [IN_W-1:0] digits);
      logic high_digit;
      high_digit = 1'b0;
      for (int k = 0; k < NUM_DIGITS; k++)
        if (digits[NIB_W*k +: NIB_W] > 4'd9) high_digit = 1'b1;
      items_in++;
      if (high_digit) items_high_digit++;
      pending_values.push_back(convert_bcd(digits));
    endfunction

    function automatic void check_value(input logic [OUT_W-1:0] tdata);
      conv_result_t got;
      conv_result_t want;
      got = tdata;
      results_checked++;
      if (pending_values.size() == 0) begin
        fail_count++;
        if (reported < 10) begin
          $display("unexpected item: value %0d len %0d", got.value, got.len);
          reported++;
        end
        return;
      end
      want = pending_values.pop_front();
      if (got.value != want.value || got.len != want.len) begin
        fail_count++;
        if (reported < 10) begin
          if (got.value != want.value)
            $display("item %0d binary_value: expected %0d, got %0d",
                     results_checked, want.value, got.value);
          if (got.len != want.len)
            $display("item %0d bit_length: expected %0d, got %0d",
                     results_checked, want.len, got.len);
          reported++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // bcd_digits[31:0]
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // binary_value[26:0], bit_length[31:27]

  conv_checker sb;
  int          idle_mode;
  int          cycle_count;

  bcd_to_binary_converter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_wait();
    case (idle_mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
      default:     return $urandom_range(0, 15);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_digits(input logic [IN_W-1:0] digits);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = digits;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_digits(digits);
    @(negedge clk);
  endtask

  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_value(m_axis_tdata);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [IN_W-1:0] directed[$];
    logic [IN_W-1:0] digits;
    int              ndig;
    int              pos;
    sb            = new;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cycle_count   = 0;
    idle_mode     = IDLE_RANDOM;
    // zero, boundaries of the correction threshold, powers of two near the
    // value width, and digits above nine including the truncating case
    directed = '{32'h00000000, 32'h00000001, 32'h00000002, 32'h00000008, 32'h00000009,
                 32'h00000010, 32'h00000099, 32'h00000100, 32'h00000080, 32'h12345678,
                 32'h87654321, 32'h67108863, 32'h67108864, 32'h10000000, 32'h80000000,
                 32'h99999999, 32'h0000000F, 32'h0AAAAAAA, 32'h0FFFFFFF, 32'h8FFFFFFF,
                 32'h55555555, 32'h9999999F};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_digits(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) idle_mode = $urandom_range(IDLE_RANDOM, IDLE_SPARSE);
      digits = '0;
      case ($urandom_range(0, 9))
        0, 1: digits = $urandom_range(0, 32'h99999999);
        2: begin
          // all nines or a lone digit: carry and weight extremes
          ndig = $urandom_range(1, NUM_DIGITS);
          pos  = $urandom_range(0, NUM_DIGITS - 1);
          if ($urandom_range(0, 1))
            for (int k = 0; k < ndig; k++) digits[NIB_W*k +: NIB_W] = 4'd9;
          else
            digits[NIB_W*pos +: NIB_W] = 4'($urandom_range(1, 9));
        end
        default: begin
          ndig = $urandom_range(1, NUM_DIGITS);
          for (int k = 0; k < ndig; k++)
            digits[NIB_W*k +: NIB_W] = 4'($urandom_range(0, 9));
        end
      endcase
      send_digits(digits);
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_values.size() != 0) begin
      $display("%0d expected items never arrived", sb.pending_values.size());
      sb.fail_count += sb.pending_values.size();
    end

    $display("sent %0d BCD items (%0d directed, %0d with digits above nine), checked %0d",
             sb.items_in, directed.size(), sb.items_high_digit, sb.results_checked);
    $display("mismatches %0d over %0d cycles", sb.fail_count, cycle_count);
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
